// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh : concurrent assertion shorthands
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/wat_pkg.sv
// ----------------------------------------------------------------------------
// wat_pkg : shared types and constants for the weekly alarm table
// Entry layout, operation codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wat_pkg;

    localparam int DEFAULT_MAX_ALARMS = 10;

    localparam int ID_W        = 8;
    localparam int HOUR_W      = 5;
    localparam int MIN_W       = 6;
    localparam int DAY_W       = 7;
    localparam int WDAY_W      = 3;
    localparam int FUNC_W      = 3;
    localparam int CAP_W       = 4;
    localparam int COUNT_OUT_W = 4;

    localparam logic [CAP_W-1:0]  CAP_RESET = 4'd10;
    localparam logic [ID_W-1:0]   FIRST_ID  = 8'd1;
    localparam logic [WDAY_W-1:0] WDAY_NONE = 3'd7;

    localparam logic [FUNC_W-1:0] FUNC_CREATE      = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE      = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY      = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_ENABLE      = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY_REP  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_CHECK       = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_MODIFY_TIME = 3'd6;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [HOUR_W-1:0] hour;
        logic [MIN_W-1:0]  minute;
        logic              enabled;
        logic              rpt;
        logic [DAY_W-1:0]  days;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_READ,
        ST_EVAL,
        ST_SHIFT_READ,
        ST_SHIFT_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_op;
        logic scan_clear;
        logic rd_scan;
        logic rd_next;
        logic idx_inc;
        logic set_found;
        logic wr_modify;
        logic wr_shift;
        logic emit_pend;
        logic set_pend;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              scan_done;
        logic              shift_done;
        logic              id_hit;
        logic              check_hit;
        logic              pend_valid;
        logic              out_free;
    } dp_status_t;

endpackage

// File: rtl/wat_datapath.sv
// ----------------------------------------------------------------------------
// wat_datapath : alarm table storage, scan index and result register
// Single-port table memory with registered read, counters, result staging.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wat_datapath
    import wat_pkg::*;
#(
    parameter int MAX_ALARMS = DEFAULT_MAX_ALARMS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  ctrl_cmd_t              cmd,
    output dp_status_t             status,
    input  logic [FUNC_W-1:0]      func,
    input  logic [ID_W-1:0]        alarm_id,
    input  logic [HOUR_W-1:0]      alarm_hour,
    input  logic [MIN_W-1:0]       alarm_minute,
    input  logic                   time_present,
    input  logic                   enable_flag,
    input  logic                   repeat_flag,
    input  logic [DAY_W-1:0]       day_mask,
    input  logic [WDAY_W-1:0]      weekday,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   success,
    output logic [ID_W-1:0]        created_id,
    output logic                   ring,
    output logic [ID_W-1:0]        ringing_id,
    output logic [COUNT_OUT_W-1:0] stored_count,
    output logic                   last_result
);

    localparam int IDX_W = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CNT_W = $clog2(MAX_ALARMS + 1);

    // request fields
    logic [FUNC_W-1:0] op_func_reg;
    logic [ID_W-1:0]   op_id_reg;
    logic [HOUR_W-1:0] op_hour_reg;
    logic [MIN_W-1:0]  op_minute_reg;
    logic              op_tpres_reg;
    logic              op_en_reg;
    logic              op_rep_reg;
    logic [DAY_W-1:0]  op_days_reg;
    logic [WDAY_W-1:0] op_wday_reg;

    logic [CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [ID_W-1:0]   next_id_reg, next_id_next;
    logic [CNT_W-1:0]  idx_reg;
    logic              found_reg;
    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_id_reg;

    entry_t            table_mem [MAX_ALARMS];
    entry_t            rd_data_reg;

    logic                   out_valid_reg, out_valid_next;
    logic                   success_reg, success_next;
    logic [ID_W-1:0]        created_id_reg, created_id_next;
    logic                   ring_reg, ring_next;
    logic [ID_W-1:0]        ringing_id_reg, ringing_id_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;
    logic                   last_reg, last_next;

    logic             full;
    logic [CNT_W-1:0] idx_plus1;
    logic [DAY_W-1:0] day_bit;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic             wr_create;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
    entry_t           mod_entry;
    logic             out_free;
    logic             out_load;

    assign cfg_ready = 1'b1;
    assign idx_plus1 = idx_reg + CNT_W'(1);
    assign full      = (8'(used_reg) >= 8'(cap_reg)) || (8'(used_reg) >= 8'(MAX_ALARMS));
    assign day_bit   = (op_wday_reg == WDAY_NONE) ? '0 : (DAY_W'(1) << op_wday_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = cmd.emit_pend || cmd.finish;

    assign status.func       = op_func_reg;
    assign status.scan_done  = (idx_reg >= used_reg);
    assign status.shift_done = (idx_plus1 >= used_reg);
    assign status.id_hit     = (rd_data_reg.id == op_id_reg);
    assign status.check_hit  = rd_data_reg.enabled
                               && (rd_data_reg.hour == op_hour_reg)
                               && (rd_data_reg.minute == op_minute_reg)
                               && (rd_data_reg.rpt || (|(rd_data_reg.days & day_bit)));
    assign status.pend_valid = pend_valid_reg;
    assign status.out_free   = out_free;

    // in-place update for the modify family
    always_comb
    begin
        mod_entry = rd_data_reg;
        if ((op_func_reg == FUNC_MODIFY_TIME) || ((op_func_reg == FUNC_MODIFY) && op_tpres_reg))
        begin
            mod_entry.hour   = op_hour_reg;
            mod_entry.minute = op_minute_reg;
        end
        if ((op_func_reg == FUNC_MODIFY) || (op_func_reg == FUNC_ENABLE))
        begin
            mod_entry.enabled = op_en_reg;
        end
        if ((op_func_reg == FUNC_MODIFY) || (op_func_reg == FUNC_MODIFY_REP))
        begin
            mod_entry.rpt  = op_rep_reg;
            mod_entry.days = op_days_reg;
        end
    end

    // memory port selection
    always_comb
    begin
        wr_create = cmd.finish && (op_func_reg == FUNC_CREATE) && !full;
        wr_en     = wr_create || cmd.wr_modify || cmd.wr_shift;
        rd_en     = cmd.rd_scan || cmd.rd_next;
        rd_addr   = cmd.rd_next ? idx_plus1[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        wr_addr   = wr_create ? used_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
        if (wr_create)
        begin
            wr_data.id      = next_id_reg;
            wr_data.hour    = op_hour_reg;
            wr_data.minute  = op_minute_reg;
            wr_data.enabled = 1'b1;
            wr_data.rpt     = op_rep_reg;
            wr_data.days    = op_days_reg;
        end
        else if (cmd.wr_shift)
        begin
            wr_data    = rd_data_reg;
            wr_data.id = ID_W'(idx_plus1);
        end
        else
        begin
            wr_data = mod_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_op)
        begin
            op_func_reg   <= func;
            op_id_reg     <= alarm_id;
            op_hour_reg   <= alarm_hour;
            op_minute_reg <= alarm_minute;
            op_tpres_reg  <= time_present;
            op_en_reg     <= enable_flag;
            op_rep_reg    <= repeat_flag;
            op_days_reg   <= day_mask;
            op_wday_reg   <= weekday;
        end
        if (cmd.set_pend)
        begin
            pend_id_reg <= rd_data_reg.id;
        end
    end

    // counters, result payload on final or intermediate result
    always_comb
    begin
        used_next       = used_reg;
        next_id_next    = next_id_reg;
        out_valid_next  = out_valid_reg;
        success_next    = success_reg;
        created_id_next = created_id_reg;
        ring_next       = ring_reg;
        ringing_id_next = ringing_id_reg;
        count_next      = count_reg;
        last_next       = last_reg;

        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cmd.emit_pend)
        begin
            success_next    = 1'b1;
            created_id_next = '0;
            ring_next       = 1'b1;
            ringing_id_next = pend_id_reg;
            count_next      = COUNT_OUT_W'(used_reg);
            last_next       = 1'b0;
        end
        else if (cmd.finish)
        begin
            success_next    = 1'b0;
            created_id_next = '0;
            ring_next       = 1'b0;
            ringing_id_next = '0;
            last_next       = 1'b1;
            case (op_func_reg) inside
                FUNC_CREATE:
                begin
                    if (!full)
                    begin
                        used_next       = used_reg + CNT_W'(1);
                        next_id_next    = next_id_reg + ID_W'(1);
                        success_next    = 1'b1;
                        created_id_next = next_id_reg;
                    end
                end
                FUNC_DELETE:
                begin
                    if (found_reg)
                    begin
                        used_next    = used_reg - CNT_W'(1);
                        next_id_next = next_id_reg - ID_W'(1);
                    end
                    success_next = found_reg;
                end
                FUNC_MODIFY, FUNC_ENABLE, FUNC_MODIFY_REP, FUNC_MODIFY_TIME:
                begin
                    success_next = found_reg;
                end
                FUNC_CHECK:
                begin
                    success_next    = 1'b1;
                    ring_next       = pend_valid_reg;
                    ringing_id_next = pend_valid_reg ? pend_id_reg : '0;
                end
                default:
                begin
                    success_next = 1'b0;
                end
            endcase
            count_next = COUNT_OUT_W'(used_next);
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= CAP_RESET;
            used_reg       <= '0;
            next_id_reg    <= FIRST_ID;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
            used_reg      <= used_next;
            next_id_reg   <= next_id_next;
            out_valid_reg <= out_valid_next;
            if (cmd.scan_clear)
            begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_inc)
                begin
                    idx_reg <= idx_plus1;
                end
                if (cmd.set_found)
                begin
                    found_reg <= 1'b1;
                end
                if (cmd.set_pend)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        success_reg    <= success_next;
        created_id_reg <= created_id_next;
        ring_reg       <= ring_next;
        ringing_id_reg <= ringing_id_next;
        count_reg      <= count_next;
        last_reg       <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign success      = success_reg;
    assign created_id   = created_id_reg;
    assign ring         = ring_reg;
    assign ringing_id   = ringing_id_reg;
    assign stored_count = count_reg;
    assign last_result  = last_reg;

endmodule

// File: rtl/wat_controller.sv
// ----------------------------------------------------------------------------
// wat_controller : operation sequencer for the weekly alarm table
// Walks the table one entry per read/evaluate pair and issues datapath commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wat_controller
    import wat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_op    = 1'b1;
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (status.func) inside
                    FUNC_DELETE, FUNC_MODIFY, FUNC_ENABLE, FUNC_MODIFY_REP,
                    FUNC_CHECK, FUNC_MODIFY_TIME:
                        state_next = ST_READ;
                    default:
                        state_next = ST_FINISH;
                endcase
            end
            ST_READ:
            begin
                if (status.scan_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_scan = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.func == FUNC_CHECK)
                begin
                    if (!status.check_hit)
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_READ;
                    end
                    else if (!status.pend_valid)
                    begin
                        cmd.set_pend = 1'b1;
                        cmd.idx_inc  = 1'b1;
                        state_next   = ST_READ;
                    end
                    else if (status.out_free)
                    begin
                        // earlier match is not the last one: send it now
                        cmd.emit_pend = 1'b1;
                        cmd.set_pend  = 1'b1;
                        cmd.idx_inc   = 1'b1;
                        state_next    = ST_READ;
                    end
                end
                else if (status.id_hit)
                begin
                    cmd.set_found = 1'b1;
                    if (status.func == FUNC_DELETE)
                    begin
                        state_next = ST_SHIFT_READ;
                    end
                    else
                    begin
                        cmd.wr_modify = 1'b1;
                        state_next    = ST_FINISH;
                    end
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_SHIFT_READ:
            begin
                if (status.shift_done)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.rd_next = 1'b1;
                    state_next  = ST_SHIFT_WRITE;
                end
            end
            ST_SHIFT_WRITE:
            begin
                cmd.wr_shift = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = ST_SHIFT_READ;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/weekly_alarm_table_match.sv
// ----------------------------------------------------------------------------
// weekly_alarm_table_match : weekly alarm table with time matching
// Create, delete, modify and check operations on a table of alarm entries.
// ----------------------------------------------------------------------------
// One request is handled at a time. The table sits in a single-port memory
// with a registered read, so the sequencer spends a read state and an
// evaluate state on every entry it visits: create and unknown codes skip the
// scan, a search or check walks the n stored entries (ending early on an id
// hit), and delete then moves every later entry down with a read and a write
// state per entry. The result register lets a new request be taken while the
// last result is still waiting; a check with several matches holds its scan
// while an earlier match waits. The capacity register may be written at any
// time the block is idle.
`timescale 1ns / 1ps

module weekly_alarm_table_match
    import wat_pkg::*;
#(
    parameter int MAX_ALARMS = DEFAULT_MAX_ALARMS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [FUNC_W-1:0]      func,
    input  logic [ID_W-1:0]        alarm_id,
    input  logic [HOUR_W-1:0]      alarm_hour,
    input  logic [MIN_W-1:0]       alarm_minute,
    input  logic                   time_present,
    input  logic                   enable_flag,
    input  logic                   repeat_flag,
    input  logic [DAY_W-1:0]       day_mask,
    input  logic [WDAY_W-1:0]      weekday,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CAP_W-1:0]       cfg_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   success,
    output logic [ID_W-1:0]        created_id,
    output logic                   ring,
    output logic [ID_W-1:0]        ringing_id,
    output logic [COUNT_OUT_W-1:0] stored_count,
    output logic                   last_result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    wat_controller u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    wat_datapath #(
        .MAX_ALARMS (MAX_ALARMS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .func         (func),
        .alarm_id     (alarm_id),
        .alarm_hour   (alarm_hour),
        .alarm_minute (alarm_minute),
        .time_present (time_present),
        .enable_flag  (enable_flag),
        .repeat_flag  (repeat_flag),
        .day_mask     (day_mask),
        .weekday      (weekday),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .success      (success),
        .created_id   (created_id),
        .ring         (ring),
        .ringing_id   (ringing_id),
        .stored_count (stored_count),
        .last_result  (last_result)
    );

endmodule

// File: rtl/wat_checker.sv
// ----------------------------------------------------------------------------
// wat_checker : port-level assertions for the weekly alarm table
// Result consistency and output hold, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wat_checker
    import wat_pkg::*;
#(
    parameter int MAX_ALARMS = DEFAULT_MAX_ALARMS
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   success,
    input logic [ID_W-1:0]        created_id,
    input logic                   ring,
    input logic [ID_W-1:0]        ringing_id,
    input logic [COUNT_OUT_W-1:0] stored_count,
    input logic                   last_result
);

    localparam int RES_W = 2 * ID_W + COUNT_OUT_W + 3;

    logic [RES_W-1:0] res_bits;
    logic             no_cid;
    logic             count_ok;

    assign res_bits = {success, created_id, ring, ringing_id, stored_count, last_result};
    assign no_cid   = (created_id == '0);
    assign count_ok = (MAX_ALARMS > 15) || (int'(stored_count) <= MAX_ALARMS);

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(res_bits))

    // only check matches come before the final result of a request
    `ASSERT_IMPLY(a_mid_is_ring, clk, rst_n, out_valid && !last_result, ring && success)

    // a ring never carries a created id
    `ASSERT_IMPLY(a_ring_clean, clk, rst_n, out_valid && ring, success && no_cid)

    // a failure is always a single final result
    `ASSERT_IMPLY(a_fail_last, clk, rst_n, out_valid && !success, last_result && !ring && no_cid)

    // the count never passes the table size
    `ASSERT_IMPLY(a_count_max, clk, rst_n, out_valid, count_ok)

endmodule

bind weekly_alarm_table_match wat_checker #(.MAX_ALARMS(MAX_ALARMS)) u_wat_checker (.*);

// File: verif/weekly_alarm_table_match_test.sv
// ----------------------------------------------------------------------------
// weekly_alarm_table_match_test : self-checking bench for the alarm table
// Walks a short directed table of requests, then random bursts across several
// capacity settings. A behavioral copy of the table predicts every result and
// a monitor compares each accepted result, field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module weekly_alarm_table_match_test;
    import wat_pkg::*;

    localparam int ALARM_SLOTS     = DEFAULT_MAX_ALARMS;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 60;
    localparam int ITEMS_PER_PHASE = 36;
    localparam int PHASES          = 5;
    localparam int HOLD_OFF        = 300;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   alarm_id;
        logic [HOUR_W-1:0] alarm_hour;
        logic [MIN_W-1:0]  alarm_minute;
        logic              time_present;
        logic              enable_flag;
        logic              repeat_flag;
        logic [DAY_W-1:0]  day_mask;
        logic [WDAY_W-1:0] weekday;
    } alarm_request_t;

    typedef struct packed {
        logic                   success;
        logic [ID_W-1:0]        created_id;
        logic                   ring;
        logic [ID_W-1:0]        ringing_id;
        logic [COUNT_OUT_W-1:0] stored_count;
        logic                   last_result;
    } alarm_result_t;

    typedef struct {
        bit               is_cfg;
        logic [CAP_W-1:0] cap_value;
        alarm_request_t   req;
        bit               typed;
        alarm_result_t    typed_res;
    } directed_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [FUNC_W-1:0]      func;
    logic [ID_W-1:0]        alarm_id;
    logic [HOUR_W-1:0]      alarm_hour;
    logic [MIN_W-1:0]       alarm_minute;
    logic                   time_present;
    logic                   enable_flag;
    logic                   repeat_flag;
    logic [DAY_W-1:0]       day_mask;
    logic [WDAY_W-1:0]      weekday;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data;
    logic                   out_valid;
    logic                   out_ready;
    logic                   success;
    logic [ID_W-1:0]        created_id;
    logic                   ring;
    logic [ID_W-1:0]        ringing_id;
    logic [COUNT_OUT_W-1:0] stored_count;
    logic                   last_result;

    // predicted table contents
    entry_t           alarm_slots [ALARM_SLOTS];
    int               slots_used;
    logic [ID_W-1:0]  next_alarm_id;
    logic [CAP_W-1:0] capacity_reg;

    alarm_result_t    expected_results [$];
    alarm_result_t    oldest_result;
    directed_row_t    directed_rows [$];
    int               error_count;
    int               hold_off_cycles;
    int               stall_tick;
    int               stall_mode;

    weekly_alarm_table_match #(
        .MAX_ALARMS(ALARM_SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .alarm_id(alarm_id),
        .alarm_hour(alarm_hour),
        .alarm_minute(alarm_minute),
        .time_present(time_present),
        .enable_flag(enable_flag),
        .repeat_flag(repeat_flag),
        .day_mask(day_mask),
        .weekday(weekday),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .success(success),
        .created_id(created_id),
        .ring(ring),
        .ringing_id(ringing_id),
        .stored_count(stored_count),
        .last_result(last_result)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int find_slot(input logic [ID_W-1:0] id);
        for (int i = 0; i < slots_used; i++)
        begin
            if (alarm_slots[i].id == id)
                return i;
        end
        return -1;
    endfunction

    task automatic predict_alarm_results(input alarm_request_t r,
                                         output alarm_result_t res_q [$]);
        alarm_result_t    res;
        int               pos;
        int               limit;
        int               i;
        int               hit_idx [$];
        logic [DAY_W-1:0] day_bit;
        res_q = {};
        res = '0;
        res.last_result = 1'b1;
        limit = (capacity_reg > ALARM_SLOTS) ? ALARM_SLOTS : int'(capacity_reg);
        pos = find_slot(r.alarm_id);
        case (r.func)
            FUNC_CREATE:
            begin
                if (slots_used < limit)
                begin
                    alarm_slots[slots_used] = '{id: next_alarm_id, hour: r.alarm_hour,
                                                minute: r.alarm_minute, enabled: 1'b1,
                                                rpt: r.repeat_flag, days: r.day_mask};
                    res.success = 1'b1;
                    res.created_id = next_alarm_id;
                    next_alarm_id = next_alarm_id + ID_W'(1);
                    slots_used++;
                end
            end
            FUNC_DELETE:
            begin
                if (pos >= 0)
                begin
                    for (i = pos; i + 1 < slots_used; i++)
                    begin
                        alarm_slots[i] = alarm_slots[i + 1];
                        alarm_slots[i].id = ID_W'(i + 1);
                    end
                    slots_used--;
                    next_alarm_id = next_alarm_id - ID_W'(1);
                end
                res.success = (pos >= 0);
            end
            FUNC_MODIFY, FUNC_ENABLE, FUNC_MODIFY_REP, FUNC_MODIFY_TIME:
            begin
                if (pos >= 0)
                begin
                    if (r.func == FUNC_MODIFY_TIME || (r.func == FUNC_MODIFY && r.time_present))
                    begin
                        alarm_slots[pos].hour = r.alarm_hour;
                        alarm_slots[pos].minute = r.alarm_minute;
                    end
                    if (r.func == FUNC_MODIFY || r.func == FUNC_ENABLE)
                        alarm_slots[pos].enabled = r.enable_flag;
                    if (r.func == FUNC_MODIFY || r.func == FUNC_MODIFY_REP)
                    begin
                        alarm_slots[pos].rpt = r.repeat_flag;
                        alarm_slots[pos].days = r.day_mask;
                    end
                end
                res.success = (pos >= 0);
            end
            FUNC_CHECK:
            begin
                day_bit = (r.weekday != WDAY_NONE) ? DAY_W'(1 << r.weekday) : '0;
                for (i = 0; i < slots_used; i++)
                begin
                    if (alarm_slots[i].enabled && alarm_slots[i].hour == r.alarm_hour &&
                        alarm_slots[i].minute == r.alarm_minute &&
                        (alarm_slots[i].rpt || (alarm_slots[i].days & day_bit) != '0))
                        hit_idx.push_back(i);
                end
                res.success = 1'b1;
            end
            default:
            begin
            end
        endcase
        res.stored_count = COUNT_OUT_W'(slots_used);
        if (hit_idx.size() == 0)
            res_q.push_back(res);
        foreach (hit_idx[k])
        begin
            res.ring = 1'b1;
            res.ringing_id = alarm_slots[hit_idx[k]].id;
            res.last_result = (k == hit_idx.size() - 1);
            res_q.push_back(res);
        end
    endtask

    function automatic alarm_request_t random_request();
        alarm_request_t r;
        int             pick;
        int             sel;
        pick = $urandom_range(0, 99);
        if (pick < 24)
            r.func = FUNC_CREATE;
        else if (pick < 36)
            r.func = FUNC_DELETE;
        else if (pick < 46)
            r.func = FUNC_MODIFY;
        else if (pick < 54)
            r.func = FUNC_ENABLE;
        else if (pick < 62)
            r.func = FUNC_MODIFY_REP;
        else if (pick < 70)
            r.func = FUNC_MODIFY_TIME;
        else if (pick < 95)
            r.func = FUNC_CHECK;
        else
            r.func = FUNC_UNUSED;
        r.alarm_id = ID_W'($urandom_range(0, 255));
        r.alarm_hour = HOUR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(24, 31)
                                                             : $urandom_range(0, 23));
        r.alarm_minute = MIN_W'(($urandom_range(0, 9) == 0) ? $urandom_range(60, 63)
                                                              : $urandom_range(0, 59));
        r.time_present = ($urandom_range(0, 1) == 1);
        r.enable_flag = ($urandom_range(0, 3) != 0);
        r.repeat_flag = ($urandom_range(0, 9) < 3);
        r.day_mask = DAY_W'($urandom_range(0, 127));
        r.weekday = WDAY_W'($urandom_range(0, 7));
        if (slots_used > 0)
        begin
            sel = $urandom_range(0, slots_used - 1);
            if ($urandom_range(0, 9) < 8)
                r.alarm_id = alarm_slots[sel].id;
            // reuse a stored time so checks hit and several entries share a time
            if ($urandom_range(0, 3) != 0)
            begin
                r.alarm_hour = alarm_slots[sel].hour;
                r.alarm_minute = alarm_slots[sel].minute;
            end
        end
        return r;
    endfunction

    function automatic directed_row_t req_row(input logic [FUNC_W-1:0] f,
                                              input logic [ID_W-1:0] id,
                                              input logic [HOUR_W-1:0] hr,
                                              input logic [MIN_W-1:0] mn,
                                              input logic tp, input logic en,
                                              input logic rep,
                                              input logic [DAY_W-1:0] days,
                                              input logic [WDAY_W-1:0] wd);
        directed_row_t row;
        row.is_cfg = 1'b0;
        row.cap_value = '0;
        row.req = '{func: f, alarm_id: id, alarm_hour: hr, alarm_minute: mn,
                    time_present: tp, enable_flag: en, repeat_flag: rep,
                    day_mask: days, weekday: wd};
        row.typed = 1'b0;
        row.typed_res = '0;
        return row;
    endfunction

    function automatic directed_row_t with_exp(input directed_row_t row, input logic ok,
                                               input logic [ID_W-1:0] cid,
                                               input logic [COUNT_OUT_W-1:0] n);
        row.typed = 1'b1;
        row.typed_res = '{success: ok, created_id: cid, ring: 1'b0, ringing_id: '0,
                          stored_count: n, last_result: 1'b1};
        return row;
    endfunction

    function automatic directed_row_t cfg_row(input logic [CAP_W-1:0] value);
        directed_row_t row;
        row = req_row(FUNC_CHECK, '0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0);
        row.is_cfg = 1'b1;
        row.cap_value = value;
        return row;
    endfunction

    task automatic report_mismatch(input string what, input logic [ID_W-1:0] want,
                                   input logic [ID_W-1:0] got);
        error_count++;
        $display("%0t mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    task automatic offer_request(input alarm_request_t r, input bit typed,
                                 input alarm_result_t typed_res);
        alarm_result_t predicted [$];
        in_valid <= 1'b1;
        func <= r.func;
        alarm_id <= r.alarm_id;
        alarm_hour <= r.alarm_hour;
        alarm_minute <= r.alarm_minute;
        time_present <= r.time_present;
        enable_flag <= r.enable_flag;
        repeat_flag <= r.repeat_flag;
        day_mask <= r.day_mask;
        weekday <= r.weekday;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_alarm_results(r, predicted);
        if (typed)
            expected_results.push_back(typed_res);
        else
            foreach (predicted[k])
                expected_results.push_back(predicted[k]);
    endtask

    task automatic wait_for_results();
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        in_valid <= 1'b0;
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        capacity_reg = value;
        cfg_valid <= 1'b0;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", '0, '0);
            end
            else
            begin
                oldest_result = expected_results.pop_front();
                if (success !== oldest_result.success)
                    report_mismatch("success", ID_W'(oldest_result.success),
                                    ID_W'(success));
                if (created_id !== oldest_result.created_id)
                    report_mismatch("created_id", oldest_result.created_id, created_id);
                if (ring !== oldest_result.ring)
                    report_mismatch("ring", ID_W'(oldest_result.ring), ID_W'(ring));
                if (ringing_id !== oldest_result.ringing_id)
                    report_mismatch("ringing_id", oldest_result.ringing_id, ringing_id);
                if (stored_count !== oldest_result.stored_count)
                    report_mismatch("stored_count", ID_W'(oldest_result.stored_count),
                                    ID_W'(stored_count));
                if (last_result !== oldest_result.last_result)
                    report_mismatch("last_result", ID_W'(oldest_result.last_result),
                                    ID_W'(last_result));
            end
        end
    end

    // receiver stall pattern, with a long hold-off on demand
    initial
    begin
        out_ready <= 1'b0;
        stall_tick = 0;
        stall_mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                hold_off_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                stall_tick++;
                if (stall_tick % 48 == 0)
                    stall_mode = $urandom_range(0, 3);
                case (stall_mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 1) == 1);
                    2:       out_ready <= (stall_tick % 4 == 0);
                    default: out_ready <= ($urandom_range(0, 7) == 0);
                endcase
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] phase_caps [PHASES];
        int               sent;
        int               burst;
        int               gap;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= '0;
        alarm_id <= '0;
        alarm_hour <= '0;
        alarm_minute <= '0;
        time_present <= 1'b0;
        enable_flag <= 1'b0;
        repeat_flag <= 1'b0;
        day_mask <= '0;
        weekday <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        error_count = 0;
        hold_off_cycles = 0;
        slots_used = 0;
        next_alarm_id = FIRST_ID;
        capacity_reg = CAP_RESET;

        directed_rows = '{
            with_exp(req_row(FUNC_CHECK, 8'd0, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 7'h00, 3'd0),
                     1'b1, 8'd0, 4'd0),
            with_exp(req_row(FUNC_DELETE, 8'd1, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 7'h00, 3'd0),
                     1'b0, 8'd0, 4'd0),
            with_exp(req_row(FUNC_MODIFY, 8'd1, 5'd12, 6'd0, 1'b1, 1'b1, 1'b1, 7'h7F, 3'd0),
                     1'b0, 8'd0, 4'd0),
            with_exp(req_row(FUNC_ENABLE, 8'd255, 5'd0, 6'd0, 1'b0, 1'b1, 1'b0, 7'h00, 3'd0),
                     1'b0, 8'd0, 4'd0),
            with_exp(req_row(FUNC_MODIFY_REP, 8'd0, 5'd0, 6'd0, 1'b0, 1'b0, 1'b1, 7'h01, 3'd0),
                     1'b0, 8'd0, 4'd0),
            with_exp(req_row(FUNC_MODIFY_TIME, 8'd1, 5'd1, 6'd1, 1'b0, 1'b0, 1'b0, 7'h00, 3'd0),
                     1'b0, 8'd0, 4'd0),
            with_exp(req_row(FUNC_UNUSED, 8'd1, 5'd0, 6'd0, 1'b1, 1'b1, 1'b1, 7'h7F, 3'd7),
                     1'b0, 8'd0, 4'd0),
            with_exp(req_row(FUNC_CREATE, 8'd0, 5'd23, 6'd59, 1'b0, 1'b0, 1'b0, 7'h7F, 3'd0),
                     1'b1, 8'd1, 4'd1),
            with_exp(req_row(FUNC_CREATE, 8'd0, 5'd0, 6'd0, 1'b0, 1'b0, 1'b1, 7'h00, 3'd0),
                     1'b1, 8'd2, 4'd2),
            with_exp(req_row(FUNC_CREATE, 8'd255, 5'd31, 6'd63, 1'b1, 1'b1, 1'b0, 7'h40, 3'd7),
                     1'b1, 8'd3, 4'd3),
            req_row(FUNC_CHECK, 8'd0, 5'd23, 6'd59, 1'b0, 1'b0, 1'b0, 7'h00, 3'd6),
            req_row(FUNC_CHECK, 8'd0, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 7'h00, 3'd7),
            req_row(FUNC_CHECK, 8'd0, 5'd31, 6'd63, 1'b0, 1'b0, 1'b0, 7'h00, 3'd7),
            req_row(FUNC_MODIFY, 8'd2, 5'd31, 6'd63, 1'b1, 1'b1, 1'b0, 7'h40, 3'd0),
            req_row(FUNC_CHECK, 8'd0, 5'd31, 6'd63, 1'b0, 1'b0, 1'b0, 7'h00, 3'd6),
            req_row(FUNC_ENABLE, 8'd3, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 7'h00, 3'd0),
            req_row(FUNC_CHECK, 8'd0, 5'd31, 6'd63, 1'b0, 1'b0, 1'b0, 7'h00, 3'd6),
            req_row(FUNC_MODIFY, 8'd1, 5'd5, 6'd5, 1'b0, 1'b1, 1'b1, 7'h00, 3'd0),
            req_row(FUNC_CHECK, 8'd0, 5'd23, 6'd59, 1'b0, 1'b0, 1'b0, 7'h00, 3'd3),
            req_row(FUNC_MODIFY_TIME, 8'd1, 5'd12, 6'd30, 1'b0, 1'b0, 1'b0, 7'h00, 3'd0),
            req_row(FUNC_MODIFY_REP, 8'd2, 5'd0, 6'd0, 1'b0, 1'b0, 1'b1, 7'h01, 3'd0),
            with_exp(req_row(FUNC_DELETE, 8'd1, 5'd0, 6'd0, 1'b0, 1'b0, 1'b0, 7'h00, 3'd0),
                     1'b1, 8'd0, 4'd2),
            req_row(FUNC_CHECK, 8'd0, 5'd31, 6'd63, 1'b0, 1'b0, 1'b0, 7'h00, 3'd0),
            with_exp(req_row(FUNC_CREATE, 8'd0, 5'd8, 6'd15, 1'b0, 1'b0, 1'b0, 7'h2A, 3'd0),
                     1'b1, 8'd3, 4'd3),
            cfg_row(4'd0),
            with_exp(req_row(FUNC_CREATE, 8'd0, 5'd8, 6'd15, 1'b0, 1'b0, 1'b0, 7'h2A, 3'd0),
                     1'b0, 8'd0, 4'd3),
            cfg_row(4'd15),
            with_exp(req_row(FUNC_CREATE, 8'd0, 5'd9, 6'd45, 1'b0, 1'b0, 1'b1, 7'h55, 3'd0),
                     1'b1, 8'd4, 4'd4),
            cfg_row(4'd2),
            with_exp(req_row(FUNC_CREATE, 8'd0, 5'd9, 6'd45, 1'b0, 1'b0, 1'b1, 7'h55, 3'd0),
                     1'b0, 8'd0, 4'd4)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_capacity(directed_rows[i].cap_value);
            else
                offer_request(directed_rows[i].req, directed_rows[i].typed,
                              directed_rows[i].typed_res);
        end

        phase_caps = '{4'd15, 4'd3, 4'd0, CAP_W'($urandom_range(0, 15)), 4'd10};
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_capacity(phase_caps[phase]);
            if (phase == 1)
            begin
                // receiver holds off while requests keep coming
                hold_off_cycles = HOLD_OFF;
                repeat (16) offer_request(random_request(), 1'b0, '0);
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                burst = $urandom_range(1, 10);
                repeat (burst)
                begin
                    offer_request(random_request(), 1'b0, '0);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if ($urandom_range(0, 15) == 0)
                begin
                    in_valid <= 1'b0;
                    wait_for_results();
                end
                else if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        in_valid <= 1'b0;
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
